@@ hdl/dwmf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dwmf_pkg
// Shared widths, constants and types of the distinct window marker finder.
// ---------------------------------------------------------------------------
package dwmf_pkg;

  localparam int SYM_W          = 8;
  localparam int POS_W          = 32;
  localparam int WLEN_W         = 5;
  localparam int MAX_WINDOW_DEF = 16;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(4);
  localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             eos;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

@@ hdl/dwmf_in_stage.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dwmf_in_stage
// Input register: holds one symbol until the detector consumes it.
// ---------------------------------------------------------------------------
module dwmf_in_stage
  import dwmf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             eos_i,
  input  logic             consume_i,
  output item_t            item_o
);

  logic             valid_q, valid_d;
  logic [SYM_W-1:0] symbol_q;
  logic             eos_q;
  logic             load;

  assign in_ready_o = !valid_q || consume_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      symbol_q <= symbol_i;
      eos_q    <= eos_i;
    end
  end

  assign item_o = '{valid: valid_q, symbol: symbol_q, eos: eos_q};

endmodule

@@ hdl/dwmf_detect.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dwmf_detect
// Window shift register, saturating symbol counter, found flag and the
// parallel pairwise compare of the newest window.
// ---------------------------------------------------------------------------
module dwmf_detect
  import dwmf_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WLEN_W-1:0] wlen_i,
  input  logic              fire_i,
  input  item_t             item_i,
  output result_t           res_o
);

  localparam int LW = $clog2(MAX_WINDOW + 1);

  logic [SYM_W-1:0] win_q [MAX_WINDOW];
  logic [SYM_W-1:0] win_d [MAX_WINDOW];
  logic [POS_W-1:0] cnt_q, cnt_d, cnt_nx;
  logic             done_q, done_d;
  logic [LW-1:0]    len;
  logic             dup;
  logic             hit;
  int               len_int;

  always_comb begin
    if (wlen_i == '0) begin
      len_int = 1;
    end else if (int'(wlen_i) > MAX_WINDOW) begin
      len_int = MAX_WINDOW;
    end else begin
      len_int = int'(wlen_i);
    end
    len = LW'(len_int);
  end

  // window after shifting in the new symbol
  always_comb begin
    win_d[0] = item_i.symbol;
    for (int k = 1; k < MAX_WINDOW; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      for (int j = i + 1; j < MAX_WINDOW; j++) begin
        if ((j < int'(len)) && (win_d[i] == win_d[j])) begin
          dup = 1'b1;
        end
      end
    end
  end

  assign cnt_nx = (cnt_q == POS_MAX) ? cnt_q : cnt_q + POS_W'(1);
  assign hit    = !done_q && (cnt_nx >= POS_W'(len)) && !dup;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = done_q;
    res_o  = '{valid: 1'b0, found: 1'b0, position: '0};
    if (fire_i) begin
      if (!done_q) begin
        cnt_d          = cnt_nx;
        res_o.valid    = hit || item_i.eos;
        res_o.found    = hit;
        res_o.position = hit ? cnt_nx : '0;
        if (hit) begin
          done_d = 1'b1;
        end
      end
      if (item_i.eos) begin
        cnt_d  = '0;
        done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // stale entries never decide a match: a match needs len symbols of this stream
  always_ff @(posedge clk_i) begin
    if (fire_i && !done_q) begin
      win_q <= win_d;
    end
  end

endmodule

@@ hdl/distinct_window_marker_finder_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// distinct_window_marker_finder_top
// Finds the first point in a byte stream where the last window_length symbols
// are all different and reports its 1-based position, or not found at its end.
//
// Channel  Dir  Signals                      Content
// s_axis   in   tvalid/tready/tdata/tlast    tdata[7:0] symbol, tlast end of stream
// m_axis   out  tvalid/tready/tdata/tuser    tdata[31:0] position, tuser[0] found
// cfg      in   cfg_we_i/cfg_wdata_i         window_length, 5 bits
//
// One symbol per cycle while the output is not stalled; each result passes the
// input register and the output register. All window pairs compare combinationally.
// Reset clears the stream state; window_length resets to 4.
// A stalled result holds the detector; the input register still takes one
// symbol while the result waits.
// ---------------------------------------------------------------------------
module distinct_window_marker_finder_top
  import dwmf_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WLEN_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SYM_W-1:0]  s_axis_tdata,   // [7:0] symbol
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [POS_W-1:0]  m_axis_tdata,   // [31:0] position
  output logic              m_axis_tuser    // [0] found
);

  logic [WLEN_W-1:0] wlen_q;
  item_t             item;
  result_t           res;
  logic              fire;
  logic              ovalid_q, ovalid_d;
  logic              found_q;
  logic [POS_W-1:0]  pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RESET;
    end else if (cfg_we_i) begin
      wlen_q <= cfg_wdata_i;
    end
  end

  assign fire = item.valid && (!ovalid_q || m_axis_tready);

  dwmf_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .symbol_i   (s_axis_tdata),
    .eos_i      (s_axis_tlast),
    .consume_i  (fire),
    .item_o     (item)
  );

  dwmf_detect #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_detect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wlen_i (wlen_q),
    .fire_i (fire),
    .item_i (item),
    .res_o  (res)
  );

  always_comb begin
    ovalid_d = ovalid_q;
    if (res.valid) begin
      ovalid_d = 1'b1;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      found_q <= res.found;
      pos_q   <= res.position;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = pos_q;
  assign m_axis_tuser  = found_q;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for distinct_window_marker_finder_top.
// A table of directed transfers is walked first: short streams, zeros against
// the cleared window, a marker on the final symbol, symbols after a marker,
// and the window length at 0, 1, 4 and 31. Random phases follow, each under
// a new window length. Streams mostly draw from a narrow alphabet so that
// markers come late or not at all, mixed with streams over all byte values
// and short streams of random bytes. A symbol-level predictor keeps its own
// window, counter and flag and queues the expected results. Both sides stall
// in random bursts except in the final phase.
// ---------------------------------------------------------------------------
module tb;
  import dwmf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_ITEMS    = 40;
  localparam int NUM_PHASES     = 9;

  typedef enum logic {ROW_SYM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [SYM_W-1:0] value;   // symbol, or window length for ROW_CFG
    logic             last;
    logic             typed;   // expected result given in the row
    logic             found;
    logic [POS_W-1:0] position;
  } plan_row_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } marker_rec_t;

  localparam int PLAN_ROWS = 23;
  localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
    '{ROW_SYM, 8'hFF, 1'b1, 1'b1, 1'b0, 32'd0},  // shorter than window
    '{ROW_SYM, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},  // zeros vs cleared window
    '{ROW_SYM, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_SYM, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_SYM, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_SYM, 8'h01, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_SYM, 8'h02, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_SYM, 8'h03, 1'b0, 1'b1, 1'b1, 32'd7},
    '{ROW_SYM, 8'hAA, 1'b0, 1'b0, 1'b0, 32'd0},  // ignored after marker
    '{ROW_SYM, 8'h55, 1'b1, 1'b0, 1'b0, 32'd0},  // end with no result
    '{ROW_SYM, 8'h10, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_SYM, 8'h20, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_SYM, 8'h30, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_SYM, 8'h40, 1'b1, 1'b1, 1'b1, 32'd4},  // marker on final symbol
    '{ROW_CFG, 8'd1,  1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_SYM, 8'h80, 1'b1, 1'b1, 1'b1, 32'd1},
    '{ROW_CFG, 8'd0,  1'b0, 1'b0, 1'b0, 32'd0},  // acts as 1
    '{ROW_SYM, 8'h7F, 1'b0, 1'b1, 1'b1, 32'd1},
    '{ROW_SYM, 8'h7F, 1'b1, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, 8'd31, 1'b0, 1'b0, 1'b0, 32'd0},  // acts as MAX_WINDOW
    '{ROW_SYM, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_SYM, 8'h01, 1'b1, 1'b1, 1'b0, 32'd0},
    '{ROW_CFG, 8'd4,  1'b0, 1'b0, 1'b0, 32'd0}
  };

  localparam logic [WLEN_W-1:0] PHASE_LEN [0:NUM_PHASES-1] = '{
    5'd16, 5'd31, 5'd2, 5'd0, 5'd14, 5'd17, 5'd1, 5'd9, 5'd4
  };

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [WLEN_W-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [SYM_W-1:0]  s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [POS_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;

  // predictor state
  logic [SYM_W-1:0]  window_q [MAX_WINDOW_DEF];
  logic [POS_W-1:0]  seen_count;
  logic              marker_hit;
  logic [WLEN_W-1:0] window_cfg;

  marker_rec_t pending_markers [$];
  marker_rec_t head_rec;

  bit quiet = 1'b0;
  int fails = 0;
  int idle_cycles = 0;
  int symbols_sent = 0;
  int streams_sent = 0;
  int results_seen = 0;
  int markers_seen = 0;
  int settings_used = 0;

  distinct_window_marker_finder_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_window();
    for (int k = 0; k < MAX_WINDOW_DEF; k++) window_q[k] = '0;
    seen_count = '0;
    marker_hit = 1'b0;
  endfunction

  // one symbol through the marker search; hit is set when a result is due
  function automatic void advance_window(input logic [SYM_W-1:0] sym, input logic last,
                                         output logic hit, output marker_rec_t rec);
    int  len;
    logic uniq;
    hit = 1'b0;
    rec = '0;
    if (!marker_hit) begin
      len = int'(window_cfg);
      if (len < 1) len = 1;
      if (len > MAX_WINDOW_DEF) len = MAX_WINDOW_DEF;
      for (int k = MAX_WINDOW_DEF - 1; k > 0; k--) window_q[k] = window_q[k-1];
      window_q[0] = sym;
      if (seen_count != POS_MAX) seen_count = seen_count + 1'b1;
      uniq = 1'b1;
      for (int a = 0; a < len; a++)
        for (int b = a + 1; b < len; b++)
          if (window_q[a] == window_q[b]) uniq = 1'b0;
      if (seen_count >= POS_W'(len) && uniq) begin
        marker_hit   = 1'b1;
        hit          = 1'b1;
        rec.found    = 1'b1;
        rec.position = seen_count;
      end else if (last) begin
        hit = 1'b1;
      end
    end
    if (last) clear_window();
  endfunction

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last,
                             input logic typed, input marker_rec_t typed_rec);
    logic        hit;
    marker_rec_t rec;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    symbols_sent++;
    if (last) streams_sent++;
    advance_window(sym, last, hit, rec);
    if (typed) pending_markers.push_back(typed_rec);
    else if (hit) pending_markers.push_back(rec);
  endtask

  // stop sending and let every queued result and any in-flight symbol clear
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_markers.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_window(input logic [WLEN_W-1:0] len);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    window_cfg = len;
    settings_used++;
  endtask

  task automatic send_stream();
    int          len;
    int          eff;
    int          alpha;
    logic [7:0]  base;
    logic [7:0]  sym;
    marker_rec_t none;
    none = '0;
    eff  = int'(window_cfg);
    if (eff < 1) eff = 1;
    if (eff > MAX_WINDOW_DEF) eff = MAX_WINDOW_DEF;
    if ($urandom_range(0, 9) == 0) begin
      // short burst of raw bytes
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++)
        send_symbol(8'($urandom_range(0, 255)), k == len - 1, 1'b0, none);
    end else begin
      len   = $urandom_range(1, 2 * eff + 6);
      alpha = ($urandom_range(0, 2) == 0) ? 256 : eff + $urandom_range(0, 3);
      base  = 8'($urandom_range(0, 255));
      for (int k = 0; k < len; k++) begin
        sym = base + 8'($urandom_range(0, alpha - 1));
        send_symbol(sym, k == len - 1, 1'b0, none);
      end
    end
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser) markers_seen++;
      if (pending_markers.size() == 0) begin
        $error("unexpected result: found %0d position %0d", m_axis_tuser, m_axis_tdata);
        fails++;
      end else begin
        head_rec = pending_markers.pop_front();
        if (m_axis_tuser !== head_rec.found) begin
          $error("found: expected %0d, got %0d", head_rec.found, m_axis_tuser);
          fails++;
        end
        if (m_axis_tdata !== head_rec.position) begin
          $error("position: expected %0d, got %0d", head_rec.position, m_axis_tdata);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** distinct_window_marker_finder_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [WLEN_W-1:0] len;
    int                start;
    window_cfg = WLEN_RESET;
    clear_window();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_CFG) begin
        set_window(PLAN[r].value[WLEN_W-1:0]);
      end else begin
        send_symbol(PLAN[r].value, PLAN[r].last, PLAN[r].typed,
                    '{found: PLAN[r].found, position: PLAN[r].position});
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      len = (ph == 7) ? WLEN_W'($urandom_range(0, 31)) : PHASE_LEN[ph];
      set_window(len);
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      start = symbols_sent;
      while (symbols_sent - start < PHASE_ITEMS) send_stream();
    end

    settle();
    $display("Sent %0d symbols in %0d streams under %0d window settings.",
             symbols_sent, streams_sent, settings_used);
    $display("Checked %0d results, %0d of them markers.", results_seen, markers_seen);
    if (fails == 0) begin
      $display("** distinct_window_marker_finder_top: PASSED **");
    end else begin
      $display("** distinct_window_marker_finder_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dwmf_pkg.sv
hdl/dwmf_in_stage.sv
hdl/dwmf_detect.sv
hdl/distinct_window_marker_finder_top.sv
test/tb.sv
